### src/aeg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aeg_pkg;

  localparam logic [2:0] MODE_STATIC  = 3'd0;
  localparam logic [2:0] MODE_PULSE   = 3'd1;
  localparam logic [2:0] MODE_LOOP    = 3'd2;
  localparam logic [2:0] MODE_ONESHOT = 3'd3;
  localparam logic [2:0] MODE_REPEAT  = 3'd4;

  localparam logic [2:0] REG_ANIM_MODE    = 3'd0;
  localparam logic [2:0] REG_BASE_AMOUNT  = 3'd1;
  localparam logic [2:0] REG_ANIM_DEPTH   = 3'd2;
  localparam logic [2:0] REG_ANIM_FLOOR   = 3'd3;
  localparam logic [2:0] REG_CYCLE_PERIOD = 3'd4;
  localparam logic [2:0] REG_ATTACK_TICKS = 3'd5;
  localparam logic [2:0] REG_HOLD_TICKS   = 3'd6;
  localparam logic [2:0] REG_DECAY_TICKS  = 3'd7;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;

  typedef enum logic [2:0] {
    SEG_ZERO,
    SEG_ATTACK,
    SEG_HOLD,
    SEG_DECAY,
    SEG_PULSE
  } env_seg_t;

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_FLOOR,
    ADD_TERM
  } add_sel_t;

  function automatic longint cos_entry(input longint k, input int ln, input int f);
    longint th;
    longint x2;
    longint h;
    longint c;
    longint p;
    bit     neg;
    th  = (Q30_TWO_PI * k) >>> ln;
    neg = 1'b0;
    if (th > Q30_PI) th = Q30_TWO_PI - th;
    if (th > Q30_HALF_PI) begin
      th  = Q30_PI - th;
      neg = 1'b1;
    end
    if (th < 0) th = 0;
    x2 = (th * th) >>> 30;
    h  = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      p = (x2 * h) >>> 30;
      case (i)
        0: h = Q30_ONE - p / 132;
        1: h = Q30_ONE - p / 90;
        2: h = Q30_ONE - p / 56;
        3: h = Q30_ONE - p / 30;
        4: h = Q30_ONE - p / 12;
        default: h = Q30_ONE - p / 2;
      endcase
      if (h < 0) h = 0;
      if (h > Q30_ONE) h = Q30_ONE;
    end
    c = neg ? -h : h;
    return (Q30_ONE - c + (longint'(1) << (29 - f))) >>> (31 - f);
  endfunction

endpackage
`default_nettype wire

### src/aeg_mod_div.sv
`timescale 1ns / 1ps
`default_nettype none
module aeg_mod_div #(
  parameter int W      = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [W-1:0]      rem,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld_q  [W];
  logic [W-1:0]      rem_q  [W];
  logic [W-1:0]      dvd_q  [W];
  logic [SIDE_W-1:0] side_q [W];

  wire              src_vld  [W];
  wire [W-1:0]      src_rem  [W];
  wire [W-1:0]      src_dvd  [W];
  wire [SIDE_W-1:0] src_side [W];

  logic [W:0]   trial   [W];
  logic [W-1:0] rem_next [W];
  logic [W-1:0] dvd_next [W];

  for (genvar g = 0; g < W; g++) begin : g_src
    if (g == 0) begin : g_first
      assign src_vld[g]  = in_vld;
      assign src_rem[g]  = '0;
      assign src_dvd[g]  = dividend;
      assign src_side[g] = side_in;
    end else begin : g_rest
      assign src_vld[g]  = vld_q[g-1];
      assign src_rem[g]  = rem_q[g-1];
      assign src_dvd[g]  = dvd_q[g-1];
      assign src_side[g] = side_q[g-1];
    end
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      trial[i] = {src_rem[i], src_dvd[i][W-1]};
      if (trial[i] >= {1'b0, divisor}) begin
        rem_next[i] = W'(trial[i] - {1'b0, divisor});
      end else begin
        rem_next[i] = trial[i][W-1:0];
      end
      dvd_next[i] = {src_dvd[i][W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < W; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < W; i++) vld_q[i] <= src_vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < W; i++) begin
        rem_q[i]  <= rem_next[i];
        dvd_q[i]  <= dvd_next[i];
        side_q[i] <= src_side[i];
      end
    end
  end

  assign out_vld  = vld_q[W-1];
  assign rem      = rem_q[W-1];
  assign side_out = side_q[W-1];

endmodule
`default_nettype wire

### src/aeg_frac_div.sv
`timescale 1ns / 1ps
`default_nettype none
module aeg_frac_div #(
  parameter int W      = 31,
  parameter int K      = 15,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [W-1:0]      num,
  input  logic [W-1:0]      den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [K-1:0]      quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld_q  [K];
  logic [W-1:0]      rem_q  [K];
  logic [W-1:0]      den_q  [K];
  logic [K-1:0]      quo_q  [K];
  logic [SIDE_W-1:0] side_q [K];

  wire              src_vld  [K];
  wire [W-1:0]      src_rem  [K];
  wire [W-1:0]      src_den  [K];
  wire [K-1:0]      src_quo  [K];
  wire [SIDE_W-1:0] src_side [K];

  logic [W:0]   trial    [K];
  logic         ge       [K];
  logic [W-1:0] rem_next [K];

  for (genvar g = 0; g < K; g++) begin : g_src
    if (g == 0) begin : g_first
      assign src_vld[g]  = in_vld;
      assign src_rem[g]  = num;
      assign src_den[g]  = den;
      assign src_quo[g]  = '0;
      assign src_side[g] = side_in;
    end else begin : g_rest
      assign src_vld[g]  = vld_q[g-1];
      assign src_rem[g]  = rem_q[g-1];
      assign src_den[g]  = den_q[g-1];
      assign src_quo[g]  = quo_q[g-1];
      assign src_side[g] = side_q[g-1];
    end
  end

  always_comb begin
    for (int i = 0; i < K; i++) begin
      trial[i] = {src_rem[i], 1'b0};
      ge[i]    = trial[i] >= {1'b0, src_den[i]};
      if (ge[i]) begin
        rem_next[i] = W'(trial[i] - {1'b0, src_den[i]});
      end else begin
        rem_next[i] = trial[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < K; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < K; i++) vld_q[i] <= src_vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < K; i++) begin
        rem_q[i]  <= rem_next[i];
        den_q[i]  <= src_den[i];
        quo_q[i]  <= {src_quo[i][K-2:0], ge[i]};
        side_q[i] <= src_side[i];
      end
    end
  end

  assign out_vld  = vld_q[K-1];
  assign quo      = quo_q[K-1];
  assign side_out = side_q[K-1];

endmodule
`default_nettype wire

### src/ahd_envelope_amount_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Attack-hold-decay envelope amount generator. Takes one time sample per cycle while in_ready
// is high and returns base + modulation + animation term clamped to 0..one in Q1.15
// (AMOUNT_FRAC_BITS fraction bits). Throughput is one item per clock unless the full output
// skid register stalls the pipe. The pipe holds the bit-per-stage period remainder divider
// followed by the bit-per-stage fraction divider. An output skid register lets the pipe
// take one more transfer while a result waits. COSINE_TABLE_ENTRIES must be a power of two.
// Write configuration only while the pipe is empty.
module ahd_envelope_amount_generator #(
  parameter int TIME_BITS            = 31,
  parameter int AMOUNT_FRAC_BITS     = 15,
  parameter int COSINE_TABLE_ENTRIES = 256,
  localparam int AMT_W = AMOUNT_FRAC_BITS + 1,
  localparam int MOD_W = AMOUNT_FRAC_BITS + 3,
  localparam int CFG_W = (TIME_BITS > AMT_W) ? TIME_BITS : AMT_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_BITS-1:0]    time_now,
  input  logic signed [MOD_W-1:0] modulation,
  input  logic signed [31:0]      trigger_time,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [AMT_W-1:0]        effective_amount,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);
  import aeg_pkg::*;

  localparam int F      = AMOUNT_FRAC_BITS;
  localparam int TB     = TIME_BITS;
  localparam int LN     = $clog2(COSINE_TABLE_ENTRIES);
  localparam int K      = (F > LN) ? F : LN;
  localparam int TCMP_W = ((TB > 31) ? TB : 31) + 2;
  localparam int ACC_W  = F + 5;
  localparam logic [AMT_W-1:0] ONE       = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0]     THREE_ONE = {2'b11, {F{1'b0}}};

  typedef struct packed {
    logic [TB-1:0]           t;
    logic signed [MOD_W-1:0] modv;
    logic signed [31:0]      trig;
  } md_side_t;

  typedef struct packed {
    env_seg_t                seg;
    logic                    pz;
    add_sel_t                add;
    logic signed [MOD_W-1:0] modv;
  } fd_side_t;

  logic [2:0]       anim_mode;
  logic [AMT_W-1:0] base_amount;
  logic [AMT_W-1:0] anim_depth;
  logic [AMT_W-1:0] anim_floor;
  logic [TB-1:0]    cycle_period;
  logic [TB-1:0]    attack_ticks;
  logic [TB-1:0]    hold_ticks;
  logic [TB-1:0]    decay_ticks;
  logic [TB:0]      ah_sum;
  logic [AMT_W-1:0] depth_c;
  logic [AMT_W-1:0] floor_c;

  logic en;

  logic [AMT_W-1:0] cos_rom [COSINE_TABLE_ENTRIES];

  for (genvar g = 0; g < COSINE_TABLE_ENTRIES; g++) begin : g_rom
    assign cos_rom[g] = AMT_W'(cos_entry(longint'(g), LN, F));
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_mode    <= '0;
      base_amount  <= '0;
      anim_depth   <= '0;
      anim_floor   <= '0;
      cycle_period <= '0;
      attack_ticks <= '0;
      hold_ticks   <= '0;
      decay_ticks  <= '0;
      ah_sum       <= '0;
    end else begin
      ah_sum <= {1'b0, attack_ticks} + {1'b0, hold_ticks};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ANIM_MODE:    anim_mode    <= cfg_data[2:0];
          REG_BASE_AMOUNT:  base_amount  <= cfg_data[AMT_W-1:0];
          REG_ANIM_DEPTH:   anim_depth   <= cfg_data[AMT_W-1:0];
          REG_ANIM_FLOOR:   anim_floor   <= cfg_data[AMT_W-1:0];
          REG_CYCLE_PERIOD: cycle_period <= cfg_data[TB-1:0];
          REG_ATTACK_TICKS: attack_ticks <= cfg_data[TB-1:0];
          REG_HOLD_TICKS:   hold_ticks   <= cfg_data[TB-1:0];
          REG_DECAY_TICKS:  decay_ticks  <= cfg_data[TB-1:0];
          default: ;
        endcase
      end
    end
  end

  assign depth_c = (anim_depth > ONE) ? ONE : anim_depth;
  assign floor_c = (anim_floor > ONE) ? ONE : anim_floor;

  // input register
  logic                    s0_vld;
  logic [TB-1:0]           s0_t;
  logic signed [MOD_W-1:0] s0_mod;
  logic signed [31:0]      s0_trig;

  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else if (en) s0_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_t    <= time_now;
      s0_mod  <= modulation;
      s0_trig <= trigger_time;
    end
  end

  // period remainder
  md_side_t      md_in;
  md_side_t      md_out;
  logic          md_vld;
  logic [TB-1:0] md_rem;

  assign md_in = '{t: s0_t, modv: s0_mod, trig: s0_trig};

  aeg_mod_div #(
    .W      (TB),
    .SIDE_W ($bits(md_side_t))
  ) u_mod_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s0_vld),
    .dividend (s0_t),
    .divisor  (cycle_period),
    .side_in  (md_in),
    .out_vld  (md_vld),
    .rem      (md_rem),
    .side_out (md_out)
  );

  // local time and contribution kind
  logic                    a_vld;
  logic [TB-1:0]           a_local;
  add_sel_t                a_add;
  logic                    a_pulse;
  logic signed [MOD_W-1:0] a_mod;
  logic [TB-1:0]           a_local_next;
  add_sel_t                a_add_next;
  logic                    a_pulse_next;
  logic [TCMP_W-1:0]       t_ext;
  logic [TCMP_W-1:0]       trig_ext;
  logic [TCMP_W-1:0]       since;

  assign t_ext    = TCMP_W'(md_out.t);
  assign trig_ext = TCMP_W'(md_out.trig);
  assign since    = t_ext - trig_ext;

  always_comb begin
    a_local_next = md_out.t;
    a_add_next   = ADD_NONE;
    a_pulse_next = 1'b0;
    case (anim_mode)
      MODE_PULSE: begin
        a_local_next = md_rem;
        a_add_next   = ADD_TERM;
        a_pulse_next = 1'b1;
      end
      MODE_LOOP, MODE_REPEAT: begin
        a_local_next = (cycle_period == '0) ? md_out.t : md_rem;
        a_add_next   = ADD_TERM;
      end
      MODE_ONESHOT: begin
        if (!md_out.trig[31]) begin
          if (t_ext >= trig_ext) begin
            a_local_next = since[TB-1:0];
            a_add_next   = ADD_TERM;
          end else begin
            a_add_next = ADD_FLOOR;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= md_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_local <= a_local_next;
      a_add   <= a_add_next;
      a_pulse <= a_pulse_next;
      a_mod   <= md_out.modv;
    end
  end

  // envelope segment
  logic          b_vld;
  logic [TB-1:0] b_num;
  logic [TB-1:0] b_den;
  fd_side_t      b_side;
  logic [TB-1:0] b_num_next;
  logic [TB-1:0] b_den_next;
  env_seg_t      b_seg_next;
  logic [TB:0]   into;

  assign into = {1'b0, a_local} - ah_sum;

  always_comb begin
    b_num_next = a_local;
    b_den_next = attack_ticks;
    b_seg_next = SEG_ZERO;
    if (a_pulse) begin
      b_seg_next = SEG_PULSE;
      b_den_next = cycle_period;
    end else if (a_local < attack_ticks) begin
      b_seg_next = SEG_ATTACK;
    end else if ({1'b0, a_local} < ah_sum) begin
      b_seg_next = SEG_HOLD;
    end else if (into < {1'b0, decay_ticks}) begin
      b_seg_next = SEG_DECAY;
      b_num_next = into[TB-1:0];
      b_den_next = decay_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_num  <= b_num_next;
      b_den  <= b_den_next;
      b_side <= '{seg: b_seg_next, pz: (cycle_period == '0), add: a_add, modv: a_mod};
    end
  end

  // fraction of segment or period
  fd_side_t     fd_out;
  logic         fd_vld;
  logic [K-1:0] fd_quo;

  aeg_frac_div #(
    .W      (TB),
    .K      (K),
    .SIDE_W ($bits(fd_side_t))
  ) u_frac_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (b_vld),
    .num      (b_num),
    .den      (b_den),
    .side_in  (b_side),
    .out_vld  (fd_vld),
    .quo      (fd_quo),
    .side_out (fd_out)
  );

  // smoothstep square
  logic          c1_vld;
  logic [F-1:0]  c1_x;
  logic [F-1:0]  c1_sq;
  logic [LN-1:0] c1_k;
  fd_side_t      c1_side;
  logic [F-1:0]  x_w;
  logic [2*F-1:0] sq_prod;

  assign x_w     = fd_quo[K-1 -: F];
  assign sq_prod = x_w * x_w;

  always_ff @(posedge clk) begin
    if (rst) c1_vld <= 1'b0;
    else if (en) c1_vld <= fd_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_x    <= x_w;
      c1_sq   <= sq_prod[2*F-1:F];
      c1_k    <= fd_out.pz ? '0 : fd_quo[K-1 -: LN];
      c1_side <= fd_out;
    end
  end

  // smoothstep scale
  logic            c2_vld;
  logic [AMT_W-1:0] c2_s;
  logic [LN-1:0]   c2_k;
  fd_side_t        c2_side;
  logic [F+1:0]    tri_w;
  logic [2*F+1:0]  s_prod;

  assign tri_w  = THREE_ONE - {1'b0, c1_x, 1'b0};
  assign s_prod = c1_sq * tri_w;

  always_ff @(posedge clk) begin
    if (rst) c2_vld <= 1'b0;
    else if (en) c2_vld <= c1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_s    <= s_prod[2*F:F];
      c2_k    <= c1_k;
      c2_side <= c1_side;
    end
  end

  // envelope value
  logic                    c3_vld;
  logic [AMT_W-1:0]        c3_env;
  add_sel_t                c3_add;
  logic signed [MOD_W-1:0] c3_mod;
  logic [AMT_W-1:0]        env_next;

  always_comb begin
    case (c2_side.seg)
      SEG_ATTACK: env_next = c2_s;
      SEG_HOLD:   env_next = ONE;
      SEG_DECAY:  env_next = ONE - c2_s;
      SEG_PULSE:  env_next = cos_rom[c2_k];
      default:    env_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) c3_vld <= 1'b0;
    else if (en) c3_vld <= c2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_env <= env_next;
      c3_add <= c2_side.add;
      c3_mod <= c2_side.modv;
    end
  end

  // animation term
  logic                    c4_vld;
  logic [F+1:0]            c4_add;
  logic signed [MOD_W-1:0] c4_mod;
  logic [2*F+1:0]          d_prod;
  logic [F+1:0]            term;
  logic [F+1:0]            add_next;

  assign d_prod = depth_c * c3_env;
  assign term   = {1'b0, floor_c} + {1'b0, d_prod[2*F:F]};

  always_comb begin
    case (c3_add)
      ADD_TERM:  add_next = term;
      ADD_FLOOR: add_next = {1'b0, floor_c};
      default:   add_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) c4_vld <= 1'b0;
    else if (en) c4_vld <= c3_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_add <= add_next;
      c4_mod <= c3_mod;
    end
  end

  // sum and clamp
  logic                    lst_vld;
  logic [AMT_W-1:0]        lst_amt;
  logic signed [ACC_W-1:0] acc;
  logic [AMT_W-1:0]        amt_next;

  assign acc = ACC_W'(signed'({1'b0, base_amount})) + ACC_W'(c4_mod)
             + ACC_W'(signed'({1'b0, c4_add}));

  always_comb begin
    if (acc < 0) amt_next = '0;
    else if (acc > ACC_W'(signed'({1'b0, ONE}))) amt_next = ONE;
    else amt_next = acc[AMT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) lst_vld <= 1'b0;
    else if (en) lst_vld <= c4_vld;
  end

  always_ff @(posedge clk) begin
    if (en) lst_amt <= amt_next;
  end

  // output skid
  logic             skid_full;
  logic [AMT_W-1:0] skid_amt;

  assign en       = !skid_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) skid_full <= 1'b0;
    end else if (lst_vld && !out_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && lst_vld && !out_ready) skid_amt <= lst_amt;
  end

  assign out_valid        = skid_full || lst_vld;
  assign effective_amount = skid_full ? skid_amt : lst_amt;

`ifndef NO_ASSERTIONS
  a_amount_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> effective_amount <= ONE)
    else $error("amount above one");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(lst_vld && !out_ready))
    else $error("skid filled without a stalled result");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_full && !out_ready |=> skid_full && $stable(skid_amt))
    else $error("skid lost its result");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_full |=> $stable(lst_amt) && $stable(lst_vld))
    else $error("pipe advanced while skid full");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import aeg_pkg::*;

  localparam int  F          = 15;
  localparam int  NTAB       = 256;
  localparam int  MAX_CYCLES = 900000;
  localparam longint ONE     = 64'd1 << F;
  localparam longint TMAX    = (64'd1 << 31) - 1;

  class amount_scoreboard;
    logic [15:0] pending[$];
    int          mismatches;

    function void note(logic [15:0] amount);
      pending.push_back(amount);
    endfunction

    function void check(logic [15:0] actual);
      logic [15:0] want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", actual);
        return;
      end
      want = pending.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= 10)
          $display("effective_amount mismatch: expected %0d actual %0d", want, actual);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [30:0]        time_now;
  logic signed [17:0] modulation;
  logic signed [31:0] trigger_time;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        effective_amount;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [30:0]        cfg_data;

  ahd_envelope_amount_generator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .time_now(time_now), .modulation(modulation), .trigger_time(trigger_time),
    .out_valid(out_valid), .out_ready(out_ready), .effective_amount(effective_amount),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  amount_scoreboard sb;
  longint cos_rom[NTAB];
  logic [2:0] r_mode;
  longint r_base, r_depth, r_floor, r_period, r_attack, r_hold, r_decay;
  bit     no_idle;
  int     cycles;
  int     rx_wait;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint raised_cosine(longint k);
    longint th, x2, h, c;
    longint dv[6];
    bit     neg;
    dv = '{132, 90, 56, 30, 12, 2};
    th  = (Q30_TWO_PI * k) / NTAB;
    neg = 1'b0;
    if (th > Q30_PI) th = Q30_TWO_PI - th;
    if (th > Q30_HALF_PI) begin
      th  = Q30_PI - th;
      neg = 1'b1;
    end
    if (th < 0) th = 0;
    x2 = (th * th) >> 30;
    h  = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      h = Q30_ONE - ((x2 * h) >> 30) / dv[i];
      if (h < 0) h = 0;
      if (h > Q30_ONE) h = Q30_ONE;
    end
    c = neg ? -h : h;
    return (Q30_ONE - c + (longint'(1) << (29 - F))) >> (31 - F);
  endfunction

  function automatic longint smooth(longint x);
    longint q;
    q = (x * x) >> F;
    return (q * (3 * ONE - 2 * x)) >> F;
  endfunction

  function automatic longint env_level(longint pos);
    longint into;
    if (pos < r_attack) return smooth((pos << F) / r_attack);
    if (pos < r_attack + r_hold) return ONE;
    into = pos - (r_attack + r_hold);
    if (into < r_decay) return ONE - smooth((into << F) / r_decay);
    return 0;
  endfunction

  function automatic logic [15:0] envelope_amount(longint t, longint m, longint trig);
    longint dep, flr, acc, k, pos;
    dep = (r_depth > ONE) ? ONE : r_depth;
    flr = (r_floor > ONE) ? ONE : r_floor;
    acc = r_base + m;
    case (r_mode)
      MODE_PULSE: begin
        k = (r_period != 0) ? ((t % r_period) * NTAB) / r_period : 0;
        if (k >= NTAB) k = NTAB - 1;
        acc += flr + ((dep * cos_rom[k]) >> F);
      end
      MODE_LOOP, MODE_REPEAT: begin
        pos = (r_period != 0) ? t % r_period : t;
        acc += flr + ((dep * env_level(pos)) >> F);
      end
      MODE_ONESHOT: begin
        if (trig >= 0) begin
          if (t >= trig) acc += flr + ((dep * env_level(t - trig)) >> F);
          else acc += flr;
        end
      end
      default: ;
    endcase
    if (acc < 0) acc = 0;
    if (acc > ONE) acc = ONE;
    return acc[15:0];
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check(effective_amount);
        rx_wait = no_idle ? 0 : $urandom_range(0, 18);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[30:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ANIM_MODE:    r_mode   = val[2:0];
      REG_BASE_AMOUNT:  r_base   = val[15:0];
      REG_ANIM_DEPTH:   r_depth  = val[15:0];
      REG_ANIM_FLOOR:   r_floor  = val[15:0];
      REG_CYCLE_PERIOD: r_period = val[30:0];
      REG_ATTACK_TICKS: r_attack = val[30:0];
      REG_HOLD_TICKS:   r_hold   = val[30:0];
      default:          r_decay  = val[30:0];
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(longint t, longint m, longint trig);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    time_now     <= t[30:0];
    modulation   <= m[17:0];
    trigger_time <= trig[31:0];
    do @(posedge clk); while (!in_ready);
    sb.note(envelope_amount(t[30:0], longint'(signed'(m[17:0])),
                            longint'(signed'(trig[31:0]))));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  function automatic longint pick_ticks();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return TMAX;
      2:       return $urandom_range(1, 20);
      7:       return $urandom & TMAX;
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic longint pick_amount();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return ONE;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  function automatic longint pick_mod();
    case ($urandom_range(0, 5))
      0:       return -65536;
      1:       return 65536;
      2:       return longint'(signed'(18'($urandom)));
      default: return longint'($urandom_range(0, 40000)) - 20000;
    endcase
  endfunction

  task automatic run_phase(int ph);
    longint span, t, trig;
    longint pick[8];
    if (ph == 0)      pick = '{MODE_LOOP, 65535, 65535, 65535, TMAX, TMAX, TMAX, TMAX};
    else if (ph == 1) pick = '{MODE_ONESHOT, 0, ONE, ONE, 0, 0, 0, 0};
    else begin
      pick[0] = (ph < 18) ? ph % 8 : $urandom_range(1, 4);
      pick[1] = pick_amount();
      pick[2] = pick_amount();
      pick[3] = ($urandom_range(0, 2) == 0) ? pick_amount() : $urandom_range(0, 4000);
      case ($urandom_range(0, 4))
        0:       pick[4] = 0;
        1:       pick[4] = TMAX;
        2:       pick[4] = $urandom_range(1, 300);
        default: pick[4] = $urandom_range(1, 12000);
      endcase
      for (int i = 5; i < 8; i++) pick[i] = pick_ticks();
    end
    for (int i = 0; i < 8; i++) write_reg(3'(i), pick[i]);
    no_idle = ($urandom_range(0, 3) == 0);
    span = r_attack + r_hold + r_decay + 2;
    if (span > TMAX) span = TMAX;
    trig = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 50000) : ($urandom & TMAX);
    send_sample(0, 0, -1);
    send_sample(TMAX, -65536, 0);
    send_sample(r_attack & TMAX, 65536, TMAX);
    send_sample((r_attack + r_hold) & TMAX, -131072, trig);
    send_sample((trig + r_attack + r_hold + r_decay) & TMAX, 131071, trig);
    send_sample((trig > 0) ? trig - 1 : 0, 0, trig);
    for (int n = 0; n < 44; n++) begin
      case ($urandom_range(0, 5))
        0:       t = $urandom & TMAX;
        1:       t = (r_period != 0 && r_period < TMAX) ?
                     longint'($urandom) % (3 * r_period + 1) : $urandom_range(0, 1000);
        2:       t = longint'($urandom) % (span + 1);
        default: t = (trig + longint'($urandom) % (span + 1)) & TMAX;
      endcase
      case ($urandom_range(0, 5))
        0:       send_sample(t, pick_mod(), -1);
        1:       send_sample(t, pick_mod(), longint'(signed'(32'($urandom))));
        default: send_sample(t, pick_mod(), trig);
      endcase
      if (n % 11 == 10) trig = $urandom_range(0, 50000);
    end
    drain();
  endtask

  initial begin
    sb           = new();
    cycles       = 0;
    no_idle      = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    time_now     = '0;
    modulation   = '0;
    trigger_time = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    r_mode = MODE_STATIC;
    r_base = 0; r_depth = 0; r_floor = 0;
    r_period = 0; r_attack = 0; r_hold = 0; r_decay = 0;
    for (int k = 0; k < NTAB; k++) cos_rom[k] = raised_cosine(k);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 25; ph++) run_phase(ph);
    if (sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
